FILE: design/smag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smagorinsky eddy viscosity package
// Internal word types, pipeline carry structures and the arithmetic steps
// used by the pipeline stages of the eddy viscosity cell.
// ----------------------------------------------------------------------------
package smag_pkg;

    typedef logic [63:0]  u64_t;
    typedef logic [127:0] u128_t;

    // Register index of the dissipation coefficient.
    localparam int REG_CE = 0;

    // Bit-serial unit depths, fixed by the 64-bit internal magnitudes.
    localparam int SQ_STEPS  = 64;
    localparam int DIV_STEPS = 64;

    // floor(x / 3) == (x * RECIP3) >> 65 for every 64-bit x.
    localparam u64_t RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

    // Four 32 x 32 partial products of a 64 x 64 multiplication.
    typedef struct packed {
        u64_t ll;
        u64_t lh;
        u64_t hl;
        u64_t hh;
    } pp_t;

    // A value with its saturation flag.
    typedef struct packed {
        u64_t val;
        logic sat;
    } sv_t;

    // Values that ride along with a request through the pipeline.
    typedef struct packed {
        u64_t bm;
        logic trneg;
        u64_t delta;
        u64_t ce;
        u64_t ck;
        u64_t ckd;
        u64_t aux;
        u64_t k;
        u64_t nut;
        logic sat;
        logic werr;
        logic zce;
    } side_t;

    typedef struct packed {
        logic [66:0] rem;
        u64_t        root;
        u128_t       x;
        side_t       sd;
    } sq_t;

    typedef struct packed {
        u64_t  rem;
        u64_t  lo;
        u64_t  quo;
        u64_t  d;
        logic  ovf;
        side_t sd;
    } dv_t;

    function automatic pp_t mul_pp(input u64_t a, input u64_t b);
        pp_t p;
        p.ll = u64_t'(a[31:0])  * u64_t'(b[31:0]);
        p.lh = u64_t'(a[31:0])  * u64_t'(b[63:32]);
        p.hl = u64_t'(a[63:32]) * u64_t'(b[31:0]);
        p.hh = u64_t'(a[63:32]) * u64_t'(b[63:32]);
        return p;
    endfunction

    function automatic u128_t pp_sum(input pp_t p);
        return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
    endfunction

    // Fixed-point rescale of a full product, saturating at 2^64-1.
    function automatic sv_t qsat(input u128_t p, input int unsigned f);
        sv_t r;
        r.sat = (p >> (64 + f)) != '0;
        r.val = r.sat ? '1 : u64_t'(p >> f);
        return r;
    endfunction

    function automatic sv_t sat_add(input u64_t a, input u64_t b);
        sv_t         r;
        logic [64:0] t;
        t     = {1'b0, a} + {1'b0, b};
        r.sat = t[64];
        r.val = t[64] ? '1 : t[63:0];
        return r;
    endfunction

    function automatic sv_t add3(input u64_t a, input u64_t b, input u64_t c);
        sv_t         r;
        logic [65:0] t;
        t     = {2'b00, a} + {2'b00, b} + {2'b00, c};
        r.sat = t[65:64] != 2'b00;
        r.val = r.sat ? '1 : t[63:0];
        return r;
    endfunction

    function automatic u64_t mag64(input logic signed [63:0] x);
        return x[63] ? u64_t'(-x) : u64_t'(x);
    endfunction

    // One bit of an integer square root: two radicand bits enter per step.
    function automatic sq_t sqrt_step(input sq_t a);
        sq_t         r;
        logic [66:0] rm;
        logic [66:0] tt;
        rm  = {a.rem[64:0], a.x[127:126]};
        tt  = {1'b0, a.root, 2'b01};
        r   = a;
        r.x = a.x << 2;
        if (rm >= tt)
        begin
            r.rem  = rm - tt;
            r.root = {a.root[62:0], 1'b1};
        end
        else
        begin
            r.rem  = rm;
            r.root = {a.root[62:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring division.
    function automatic dv_t div_step(input dv_t a);
        dv_t         r;
        logic [64:0] r2;
        r2   = {a.rem, a.lo[63]};
        r    = a;
        r.lo = a.lo << 1;
        if (r2 >= {1'b0, a.d})
        begin
            r.rem = 64'(r2 - {1'b0, a.d});
            r.quo = {a.quo[62:0], 1'b1};
        end
        else
        begin
            r.rem = r2[63:0];
            r.quo = {a.quo[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: design/smagorinsky_eddy_viscosity_cell_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smagorinsky eddy viscosity cell
// Per mesh cell, solves the subgrid energy equation and returns k, the eddy
// viscosity and the dissipation rate in saturating fixed point.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         start (accepted, busy low) grad_*, filter_width, cell_ck
//   result    out        done, one cycle            turb_energy, eddy_viscosity,
//                                                   dissipation, saturated, width_error
//   config    in/out     APB write, pready high     ce_coefficient at offset 0
//
// A request may enter on every clock; busy never rises. Results leave in the
// order of their requests. The latency is set by three
// 64-stage bit-serial units (square root and two dividers) plus the
// multiplier stages. Reset clears the valid chain and loads the default
// coefficient. Results cannot be stalled.
// ----------------------------------------------------------------------------
module smagorinsky_eddy_viscosity_cell_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    localparam int DATA_BITS = (WORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_BITS-1:0]        paddr,
    input  logic [DATA_BITS-1:0]        pwdata,
    output logic [DATA_BITS-1:0]        prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] grad_xx,
    input  logic signed [WORD_BITS-1:0] grad_xy,
    input  logic signed [WORD_BITS-1:0] grad_xz,
    input  logic signed [WORD_BITS-1:0] grad_yx,
    input  logic signed [WORD_BITS-1:0] grad_yy,
    input  logic signed [WORD_BITS-1:0] grad_yz,
    input  logic signed [WORD_BITS-1:0] grad_zx,
    input  logic signed [WORD_BITS-1:0] grad_zy,
    input  logic signed [WORD_BITS-1:0] grad_zz,
    input  logic [WORD_BITS-1:0]        filter_width,
    input  logic [WORD_BITS-1:0]        cell_ck,
    output logic                        done,
    output logic [WORD_BITS-1:0]        turb_energy,
    output logic [WORD_BITS-1:0]        eddy_viscosity,
    output logic [WORD_BITS-1:0]        dissipation,
    output logic                        saturated,
    output logic                        width_error
);

    import smag_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int LAT = 16 + SQ_STEPS + 3 + DIV_STEPS + 9 + DIV_STEPS + 1;
    localparam logic [W-1:0] CE_RESET = W'(((64'd1048 << F) + 64'd500) / 64'd1000);
    localparam u64_t WMASK = (u64_t'(1) << W) - u64_t'(1);

    // ------------------------------------------------------------------
    // Control: valid chain and configuration register
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic [W-1:0]   ce_coefficient_reg;
    logic           cfg_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = DATA_BITS'(ce_coefficient_reg);
    assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_BITS-1] == 1'(REG_CE));
    assign done   = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg            <= '0;
            ce_coefficient_reg <= CE_RESET;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
            if (cfg_wr)
            begin
                ce_coefficient_reg <= pwdata[W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Front stages: strain invariants, b, q and the discriminant
    // ------------------------------------------------------------------
    logic signed [W-1:0] g0_reg [9];
    logic [W-1:0]        dl0_reg;
    logic [W-1:0]        ck0_reg;
    logic [W-1:0]        ce0_reg;
    logic signed [63:0]  gx [9];
    logic signed [63:0]  tr1;
    u64_t                m1_next [6];
    side_t               sd1_next;

    u64_t  m1_reg [6];
    u64_t  trm1_reg;
    side_t sd_reg [1:15];
    pp_t   pp2_reg [8];
    u128_t pr3_reg [8];
    sv_t   sq4_reg [6];
    sv_t   ckq4;
    side_t sd4_next;
    sv_t   p5_next;
    sv_t   s5_next;
    side_t sd5_next;
    u64_t  p5_reg;
    u64_t  s5_reg;
    pp_t   pp6a_reg;
    pp_t   pp6b_reg;
    u64_t  sv6_reg;
    u128_t pr7a_reg;
    u128_t pr7b_reg;
    u64_t  sv7_reg;
    sv_t   q8_next;
    sv_t   bb8_next;
    side_t sd8_next;
    u64_t  q8_reg;
    pp_t   pp9_reg;
    u128_t pr10_reg;
    sv_t   t11_next;
    side_t sd11_next;
    u64_t  t11_reg;
    pp_t   pp12_reg;
    u128_t pr13_reg;
    sv_t   u14_next;
    side_t sd14_next;
    u64_t  u14_reg;
    u64_t  u8_15;
    logic  u8_sat;
    sv_t   e15_next;
    side_t sd15_next;
    u64_t  e15_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            gx[i] = 64'(g0_reg[i]);
        end
        m1_next[0] = mag64(gx[0] - gx[4]);
        m1_next[1] = mag64(gx[4] - gx[8]);
        m1_next[2] = mag64(gx[8] - gx[0]);
        m1_next[3] = mag64(gx[1] + gx[3]);
        m1_next[4] = mag64(gx[2] + gx[6]);
        m1_next[5] = mag64(gx[5] + gx[7]);
        tr1        = gx[0] + gx[4] + gx[8];
        sd1_next       = '0;
        sd1_next.trneg = tr1[63];
        sd1_next.delta = u64_t'(dl0_reg);
        sd1_next.ck    = u64_t'(ck0_reg);
        sd1_next.ce    = u64_t'(ce0_reg);
        sd1_next.werr  = dl0_reg == '0;
        sd1_next.zce   = ce0_reg == '0;
    end

    always_comb
    begin
        ckq4         = qsat(pr3_reg[7], F);
        sd4_next     = sd_reg[3];
        sd4_next.bm  = u64_t'(pr3_reg[6][127:65]);
        sd4_next.ckd = ckq4.val;
        sd4_next.sat = sd_reg[3].sat | ckq4.sat;
    end

    always_comb
    begin
        p5_next      = add3(sq4_reg[0].val, sq4_reg[1].val, sq4_reg[2].val);
        s5_next      = add3(sq4_reg[3].val, sq4_reg[4].val, sq4_reg[5].val);
        sd5_next     = sd_reg[4];
        sd5_next.sat = sd_reg[4].sat | p5_next.sat | s5_next.sat
                     | sq4_reg[0].sat | sq4_reg[1].sat | sq4_reg[2].sat
                     | sq4_reg[3].sat | sq4_reg[4].sat | sq4_reg[5].sat;
    end

    always_comb
    begin
        q8_next       = sat_add(u64_t'(pr7a_reg[127:65]), sv7_reg >> 1);
        bb8_next      = qsat(pr7b_reg, F);
        sd8_next      = sd_reg[7];
        sd8_next.aux  = bb8_next.val;
        sd8_next.sat  = sd_reg[7].sat | q8_next.sat | bb8_next.sat;
        t11_next      = qsat(pr10_reg, F);
        sd11_next     = sd_reg[10];
        sd11_next.sat = sd_reg[10].sat | t11_next.sat;
        u14_next      = qsat(pr13_reg, F);
        sd14_next     = sd_reg[13];
        sd14_next.sat = sd_reg[13].sat | u14_next.sat;
    end

    // 4ac term is eight times Ce*Ck*q; then the b^2 term is added.
    always_comb
    begin
        u8_sat        = u14_reg > ('1 >> 3);
        u8_15         = u8_sat ? '1 : (u14_reg << 3);
        e15_next      = sat_add(sd_reg[14].aux, u8_15);
        sd15_next     = sd_reg[14];
        sd15_next.sat = sd_reg[14].sat | u8_sat | e15_next.sat;
    end

    always_ff @(posedge clk)
    begin
        g0_reg[0] <= grad_xx;
        g0_reg[1] <= grad_xy;
        g0_reg[2] <= grad_xz;
        g0_reg[3] <= grad_yx;
        g0_reg[4] <= grad_yy;
        g0_reg[5] <= grad_yz;
        g0_reg[6] <= grad_zx;
        g0_reg[7] <= grad_zy;
        g0_reg[8] <= grad_zz;
        dl0_reg   <= filter_width;
        ck0_reg   <= cell_ck;
        ce0_reg   <= ce_coefficient_reg;

        for (int i = 0; i < 6; i++)
        begin
            m1_reg[i]  <= m1_next[i];
            pp2_reg[i] <= mul_pp(m1_reg[i], m1_reg[i]);
            sq4_reg[i] <= qsat(pr3_reg[i], F);
        end
        trm1_reg  <= mag64(tr1);
        sd_reg[1] <= sd1_next;

        pp2_reg[6] <= mul_pp(trm1_reg << 1, RECIP3);
        pp2_reg[7] <= mul_pp(sd_reg[1].ck, sd_reg[1].delta);
        sd_reg[2]  <= sd_reg[1];

        for (int i = 0; i < 8; i++)
        begin
            pr3_reg[i] <= pp_sum(pp2_reg[i]);
        end
        sd_reg[3] <= sd_reg[2];
        sd_reg[4] <= sd4_next;

        p5_reg    <= p5_next.val;
        s5_reg    <= s5_next.val;
        sd_reg[5] <= sd5_next;

        pp6a_reg  <= mul_pp(p5_reg, RECIP3);
        pp6b_reg  <= mul_pp(sd_reg[5].bm, sd_reg[5].bm);
        sv6_reg   <= s5_reg;
        sd_reg[6] <= sd_reg[5];

        pr7a_reg  <= pp_sum(pp6a_reg);
        pr7b_reg  <= pp_sum(pp6b_reg);
        sv7_reg   <= sv6_reg;
        sd_reg[7] <= sd_reg[6];

        q8_reg    <= q8_next.val;
        sd_reg[8] <= sd8_next;

        pp9_reg   <= mul_pp(sd_reg[8].ck, q8_reg);
        sd_reg[9] <= sd_reg[8];

        pr10_reg   <= pp_sum(pp9_reg);
        sd_reg[10] <= sd_reg[9];

        t11_reg    <= t11_next.val;
        sd_reg[11] <= sd11_next;

        pp12_reg   <= mul_pp(sd_reg[11].ce, t11_reg);
        sd_reg[12] <= sd_reg[11];

        pr13_reg   <= pp_sum(pp12_reg);
        sd_reg[13] <= sd_reg[12];

        u14_reg    <= u14_next.val;
        sd_reg[14] <= sd14_next;

        e15_reg    <= e15_next.val;
        sd_reg[15] <= sd15_next;
    end

    // ------------------------------------------------------------------
    // Square root of e * 2^F, one root bit per stage
    // ------------------------------------------------------------------
    sq_t sq_init;
    sq_t sq_reg [SQ_STEPS];

    always_comb
    begin
        sq_init      = '0;
        sq_init.x    = u128_t'(e15_reg) << F;
        sq_init.sd   = sd_reg[15];
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                sq_reg[i] <= sqrt_step(sq_init);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                sq_reg[i] <= sqrt_step(sq_reg[i-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // s = num * delta / (2 Ce)
    // ------------------------------------------------------------------
    sv_t   num_add;
    u64_t  num16_next;
    side_t sd16_next;
    u64_t  num16_reg;
    side_t sd16_reg;
    pp_t   pp17_reg;
    side_t sd17_reg;
    u128_t pr18_reg;
    side_t sd18_reg;
    dv_t   dv1_init;
    dv_t   dv1_reg [DIV_STEPS];

    always_comb
    begin
        num_add   = sat_add(sq_reg[SQ_STEPS-1].root, sq_reg[SQ_STEPS-1].sd.bm);
        sd16_next = sq_reg[SQ_STEPS-1].sd;
        if (sd16_next.trneg)
        begin
            num16_next    = num_add.val;
            sd16_next.sat = sq_reg[SQ_STEPS-1].sd.sat | num_add.sat;
        end
        else if (sq_reg[SQ_STEPS-1].root > sq_reg[SQ_STEPS-1].sd.bm)
        begin
            num16_next = sq_reg[SQ_STEPS-1].root - sq_reg[SQ_STEPS-1].sd.bm;
        end
        else
        begin
            num16_next = '0;
        end
    end

    // The quotient overflows 64 bits exactly when the high half reaches d.
    always_comb
    begin
        dv1_init     = '0;
        dv1_init.rem = pr18_reg[127:64];
        dv1_init.lo  = pr18_reg[63:0];
        dv1_init.d   = sd18_reg.ce << 1;
        dv1_init.ovf = pr18_reg[127:64] >= (sd18_reg.ce << 1);
        dv1_init.sd  = sd18_reg;
    end

    always_ff @(posedge clk)
    begin
        num16_reg <= num16_next;
        sd16_reg  <= sd16_next;
        pp17_reg  <= mul_pp(num16_reg, sd16_reg.delta);
        sd17_reg  <= sd16_reg;
        pr18_reg  <= pp_sum(pp17_reg);
        sd18_reg  <= sd17_reg;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div1
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                dv1_reg[i] <= div_step(dv1_init);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                dv1_reg[i] <= div_step(dv1_reg[i-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // k = s^2, nut = Ck delta s, and the dissipation numerator Ce k s
    // ------------------------------------------------------------------
    side_t sd19_next;
    side_t sd19_reg;
    pp_t   pp20a_reg;
    pp_t   pp20b_reg;
    side_t sd20_reg;
    u128_t pr21a_reg;
    u128_t pr21b_reg;
    side_t sd21_reg;
    sv_t   k22_next;
    sv_t   n22_next;
    side_t sd22_next;
    side_t sd22_reg;
    pp_t   pp23_reg;
    side_t sd23_reg;
    u128_t pr24_reg;
    side_t sd24_reg;
    sv_t   m25_next;
    side_t sd25_next;
    u64_t  m25_reg;
    side_t sd25_reg;
    pp_t   pp26_reg;
    side_t sd26_reg;
    u128_t pr27_reg;
    side_t sd27_reg;
    dv_t   dv2_init;
    dv_t   dv2_reg [DIV_STEPS];

    always_comb
    begin
        sd19_next     = dv1_reg[DIV_STEPS-1].sd;
        sd19_next.aux = dv1_reg[DIV_STEPS-1].ovf ? '1 : dv1_reg[DIV_STEPS-1].quo;
        sd19_next.sat = dv1_reg[DIV_STEPS-1].sd.sat | dv1_reg[DIV_STEPS-1].ovf;
        k22_next      = qsat(pr21a_reg, F);
        n22_next      = qsat(pr21b_reg, F);
        sd22_next     = sd21_reg;
        sd22_next.k   = k22_next.val;
        sd22_next.nut = n22_next.val;
        sd22_next.sat = sd21_reg.sat | k22_next.sat | n22_next.sat;
        m25_next      = qsat(pr24_reg, F);
        sd25_next     = sd24_reg;
        sd25_next.sat = sd24_reg.sat | m25_next.sat;
    end

    always_comb
    begin
        dv2_init     = '0;
        dv2_init.rem = pr27_reg[127:64];
        dv2_init.lo  = pr27_reg[63:0];
        dv2_init.d   = sd27_reg.delta;
        dv2_init.ovf = pr27_reg[127:64] >= sd27_reg.delta;
        dv2_init.sd  = sd27_reg;
    end

    always_ff @(posedge clk)
    begin
        sd19_reg     <= sd19_next;
        pp20a_reg    <= mul_pp(sd19_reg.aux, sd19_reg.aux);
        pp20b_reg    <= mul_pp(sd19_reg.ckd, sd19_reg.aux);
        sd20_reg     <= sd19_reg;
        pr21a_reg    <= pp_sum(pp20a_reg);
        pr21b_reg    <= pp_sum(pp20b_reg);
        sd21_reg     <= sd20_reg;
        sd22_reg     <= sd22_next;
        pp23_reg     <= mul_pp(sd22_reg.ce, sd22_reg.k);
        sd23_reg     <= sd22_reg;
        pr24_reg     <= pp_sum(pp23_reg);
        sd24_reg     <= sd23_reg;
        m25_reg      <= m25_next.val;
        sd25_reg     <= sd25_next;
        pp26_reg     <= mul_pp(m25_reg, sd25_reg.aux);
        sd26_reg     <= sd25_reg;
        pr27_reg     <= pp_sum(pp26_reg);
        sd27_reg     <= sd26_reg;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div2
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                dv2_reg[i] <= div_step(dv2_init);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                dv2_reg[i] <= div_step(dv2_reg[i-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Clip to the output word and apply the special cases
    // ------------------------------------------------------------------
    dv_t          fin;
    u64_t         eps_fin;
    logic         k_over;
    logic         n_over;
    logic         e_over;
    logic [W-1:0] k_next;
    logic [W-1:0] n_next;
    logic [W-1:0] e_next;
    logic         sat_next;
    logic         werr_next;
    logic [W-1:0] turb_energy_reg;
    logic [W-1:0] eddy_viscosity_reg;
    logic [W-1:0] dissipation_reg;
    logic         saturated_reg;
    logic         width_error_reg;

    always_comb
    begin
        fin       = dv2_reg[DIV_STEPS-1];
        eps_fin   = fin.ovf ? '1 : fin.quo;
        k_over    = (fin.sd.k & ~WMASK) != '0;
        n_over    = (fin.sd.nut & ~WMASK) != '0;
        e_over    = (eps_fin & ~WMASK) != '0;
        k_next    = k_over ? '1 : fin.sd.k[W-1:0];
        n_next    = n_over ? '1 : fin.sd.nut[W-1:0];
        e_next    = e_over ? '1 : eps_fin[W-1:0];
        sat_next  = fin.sd.sat | fin.ovf | k_over | n_over | e_over;
        werr_next = 1'b0;
        // A zero filter width or a zero coefficient forces every result to zero.
        if (fin.sd.werr || fin.sd.zce)
        begin
            k_next    = '0;
            n_next    = '0;
            e_next    = '0;
            sat_next  = 1'b0;
            werr_next = fin.sd.werr;
        end
    end

    always_ff @(posedge clk)
    begin
        turb_energy_reg    <= k_next;
        eddy_viscosity_reg <= n_next;
        dissipation_reg    <= e_next;
        saturated_reg      <= sat_next;
        width_error_reg    <= werr_next;
    end

    assign turb_energy    = turb_energy_reg;
    assign eddy_viscosity = eddy_viscosity_reg;
    assign dissipation    = dissipation_reg;
    assign saturated      = saturated_reg;
    assign width_error    = width_error_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not produce a result after the pipeline latency");

    a_width_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && width_error) |-> (turb_energy == '0 && eddy_viscosity == '0
                                   && dissipation == '0 && !saturated))
        else $error("zero filter width result is not all zero");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[LAT-2]))
        else $error("result strobe without a request in the last stage");

endmodule

FILE: dv/tb_smagorinsky_eddy_viscosity_cell_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eddy viscosity cell testbench
// Streams gradient requests into the cell, predicts k, nut and epsilon with a
// bit-exact fixed-point predictor and checks every result in order. The run
// goes through several dissipation coefficients and sender idling patterns.
// ----------------------------------------------------------------------------
module tb_smagorinsky_eddy_viscosity_cell_top;
    import smag_pkg::*;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int PHASE_ITEMS = 300;
    localparam logic [31:0] CE_RESET = 32'd68682;

    typedef struct {
        logic signed [WB-1:0] g[9];
        logic [WB-1:0]        delta;
        logic [WB-1:0]        ck;
    } cell_req_t;

    typedef struct {
        logic [WB-1:0] k;
        logic [WB-1:0] nut;
        logic [WB-1:0] eps;
        logic          sat;
        logic          werr;
    } cell_res_t;

    class eddy_scoreboard;
        cell_res_t   pending[$];
        logic [31:0] ce;
        int          errors;
        int          checked;

        function new();
            ce      = CE_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function u64_t mulq(input u64_t a, input u64_t b, inout logic sat);
            u128_t p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:64+FB] != '0)
            begin
                sat = 1'b1;
                return '1;
            end
            return u64_t'(p >> FB);
        endfunction

        function u64_t addsat(input u64_t a, input u64_t b, inout logic sat);
            logic [64:0] t;
            t = {1'b0, a} + {1'b0, b};
            if (t[64])
            begin
                sat = 1'b1;
                return '1;
            end
            return t[63:0];
        endfunction

        function u64_t divsat(input u128_t n, input u64_t d, inout logic sat);
            u128_t qv;
            qv = n / {64'd0, d};
            if (qv[127:64] != '0)
            begin
                sat = 1'b1;
                return '1;
            end
            return qv[63:0];
        endfunction

        function u64_t root(input u128_t x);
            u64_t  r;
            u64_t  c;
            u128_t cc;
            r = '0;
            for (int i = 63; i >= 0; i--)
            begin
                c  = r | (u64_t'(1) << i);
                cc = {64'd0, c} * {64'd0, c};
                if (cc <= x)
                    r = c;
            end
            return r;
        endfunction

        function u64_t absdiff(input logic signed [63:0] x);
            return x < 0 ? u64_t'(-x) : u64_t'(x);
        endfunction

        function u64_t clipw(input u64_t v, inout logic sat);
            if (v > 64'hFFFF_FFFF)
            begin
                sat = 1'b1;
                return 64'hFFFF_FFFF;
            end
            return v;
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(input cell_req_t rq);
            cell_res_t         rs;
            logic signed [63:0] g[9];
            logic signed [63:0] tr;
            u64_t p, sv, q, bm, e, r, num, s, k, nut, eps, dl, ckv, cev, d;
            logic sat;
            sat = 1'b0;
            for (int i = 0; i < 9; i++)
                g[i] = 64'(rq.g[i]);
            dl  = {32'd0, rq.delta};
            ckv = {32'd0, rq.ck};
            cev = {32'd0, ce};
            rs  = '{default: '0};
            if (dl == 0)
                rs.werr = 1'b1;
            else if (cev != 0)
            begin
                d  = absdiff(g[0] - g[4]);
                p  = mulq(d, d, sat);
                d  = absdiff(g[4] - g[8]);
                p  = addsat(p, mulq(d, d, sat), sat);
                d  = absdiff(g[8] - g[0]);
                p  = addsat(p, mulq(d, d, sat), sat);
                d  = absdiff(g[1] + g[3]);
                sv = mulq(d, d, sat);
                d  = absdiff(g[2] + g[6]);
                sv = addsat(sv, mulq(d, d, sat), sat);
                d  = absdiff(g[5] + g[7]);
                sv = addsat(sv, mulq(d, d, sat), sat);
                q  = addsat(p / 3, sv / 2, sat);
                tr = g[0] + g[4] + g[8];
                bm = (2 * absdiff(tr)) / 3;
                e  = mulq(cev, mulq(ckv, q, sat), sat);
                if (e > (64'hFFFF_FFFF_FFFF_FFFF >> 3))
                begin
                    sat = 1'b1;
                    e   = '1;
                end
                else
                    e = e << 3;
                e = addsat(mulq(bm, bm, sat), e, sat);
                r = root({64'd0, e} << FB);
                if (tr < 0)
                    num = addsat(r, bm, sat);
                else
                    num = r > bm ? r - bm : '0;
                s   = divsat({64'd0, num} * {64'd0, dl}, 2 * cev, sat);
                k   = mulq(s, s, sat);
                nut = mulq(mulq(ckv, dl, sat), s, sat);
                eps = divsat({64'd0, mulq(cev, k, sat)} * {64'd0, s}, dl, sat);
                rs.k   = clipw(k, sat);
                rs.nut = clipw(nut, sat);
                rs.eps = clipw(eps, sat);
                rs.sat = sat;
            end
            pending.push_back(rs);
        endfunction

        function void compare(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input cell_res_t act);
            cell_res_t ex;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding, got k %0h", $time, act.k);
                return;
            end
            ex = pending.pop_front();
            checked++;
            compare("turb_energy", ex.k, act.k);
            compare("eddy_viscosity", ex.nut, act.nut);
            compare("dissipation", ex.eps, act.eps);
            compare("saturated", ex.sat, act.sat);
            compare("width_error", ex.werr, act.werr);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic start;
    logic busy;
    logic signed [WB-1:0] grad_xx, grad_xy, grad_xz, grad_yx, grad_yy;
    logic signed [WB-1:0] grad_yz, grad_zx, grad_zy, grad_zz;
    logic [WB-1:0] filter_width;
    logic [WB-1:0] cell_ck;
    logic done;
    logic [WB-1:0] turb_energy;
    logic [WB-1:0] eddy_viscosity;
    logic [WB-1:0] dissipation;
    logic saturated;
    logic width_error;

    eddy_scoreboard sb;
    int idle_pct;
    int sent;

    smagorinsky_eddy_viscosity_cell_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .grad_xx(grad_xx), .grad_xy(grad_xy), .grad_xz(grad_xz),
        .grad_yx(grad_yx), .grad_yy(grad_yy), .grad_yz(grad_yz),
        .grad_zx(grad_zx), .grad_zy(grad_zy), .grad_zz(grad_zz),
        .filter_width(filter_width), .cell_ck(cell_ck),
        .done(done), .turb_energy(turb_energy), .eddy_viscosity(eddy_viscosity),
        .dissipation(dissipation), .saturated(saturated), .width_error(width_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        cell_res_t act;
        if (rst_n && done)
        begin
            act.k    = turb_energy;
            act.nut  = eddy_viscosity;
            act.eps  = dissipation;
            act.sat  = saturated;
            act.werr = width_error;
            sb.check_result(act);
        end
    end

    task automatic write_ce(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_CE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.ce = value;
    endtask

    // Sends one request, possibly after an idle gap, and returns once accepted.
    task automatic send_request(input cell_req_t rq);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        grad_xx      <= rq.g[0];
        grad_xy      <= rq.g[1];
        grad_xz      <= rq.g[2];
        grad_yx      <= rq.g[3];
        grad_yy      <= rq.g[4];
        grad_yz      <= rq.g[5];
        grad_zx      <= rq.g[6];
        grad_zy      <= rq.g[7];
        grad_zz      <= rq.g[8];
        filter_width <= rq.delta;
        cell_ck      <= rq.ck;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rq);
        sent++;
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return 32'($signed($urandom_range(1 << 19, 0)) - (1 << 18));
            2: return 32'($signed($urandom_range(1 << 25, 0)) - (1 << 24));
            default: return 32'($signed($urandom_range(256, 0)) - 128);
        endcase
    endfunction

    function automatic cell_req_t rand_request();
        cell_req_t rq;
        for (int i = 0; i < 9; i++)
            rq.g[i] = rand_grad();
        case ($urandom_range(19, 0))
            0: rq.delta = '0;
            1, 2, 3: rq.delta = $urandom();
            default: rq.delta = $urandom_range(1 << 20, 1);
        endcase
        rq.ck = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(1 << 16, 0);
        return rq;
    endfunction

    function automatic cell_req_t fill_request(input logic [31:0] gv, input logic [31:0] dl,
                                              input logic [31:0] ckv);
        cell_req_t rq;
        for (int i = 0; i < 9; i++)
            rq.g[i] = gv;
        rq.delta = dl;
        rq.ck    = ckv;
        return rq;
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        cell_req_t rq;
        logic [31:0] ce_plan[6];
        int idle_plan[6];
        sb       = new();
        sent     = 0;
        idle_pct = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        {grad_xx, grad_xy, grad_xz, grad_yx, grad_yy} = '0;
        {grad_yz, grad_zx, grad_zy, grad_zz} = '0;
        filter_width = '0;
        cell_ck      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, then eight random ones, at the reset coefficient.
        send_request(fill_request('0, '0, 32'd6160));
        send_request(fill_request('0, 32'h0001_0000, 32'd6160));
        send_request(fill_request(32'h7FFF_FFFF, '1, '1));
        send_request(fill_request(32'h8000_0000, '1, '1));
        send_request(fill_request(32'h8000_0000, 32'd1, 32'd1));
        send_request(fill_request(32'h0001_0000, 32'h0001_0000, 32'd6160));
        send_request(fill_request(32'hFFFF_0000, 32'h0001_0000, 32'd6160));
        send_request(fill_request(32'h0000_8000, 32'h0001_0000, '0));
        send_request(fill_request(32'hFFFF_8000, 32'h0001_0000, '0));
        rq = fill_request('0, 32'h0000_4000, 32'd6160);
        rq.g[1] = 32'h0002_0000;
        rq.g[3] = 32'h0001_0000;
        send_request(rq);
        rq.g[0] = 32'h7FFF_FFFF;
        rq.g[4] = 32'h8000_0000;
        send_request(rq);
        rq = fill_request(32'h0000_1000, 32'h0100_0000, 32'd6160);
        rq.g[2] = 32'h7FFF_FFFF;
        rq.g[6] = 32'h7FFF_FFFF;
        send_request(rq);
        rq.delta = '0;
        send_request(rq);
        for (int i = 0; i < 8; i++)
            send_request(rand_request());
        start <= 1'b0;
        wait_drained();

        ce_plan   = '{CE_RESET, 32'hFFFF_FFFF, 32'd1, 32'd0, $urandom(), 32'h0001_0000};
        idle_plan = '{0, 63, 63, 33, 0, 33};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph != 0)
                write_ce(ce_plan[ph]);
            idle_pct = idle_plan[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(rand_request());
            start <= 1'b0;
            wait_drained();
        end

        repeat (240) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
        end
        $display("Sent %0d cell requests and checked %0d results", sent, sb.checked);
        $display("Coefficients covered reset, zero, one, full scale and random values");
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
